// ----- rtl/s2c_pkg.sv -----
// ----------------------------------------------------------------------------
// s2c_pkg: shared types and constants of the polar to Cartesian converter
// Field widths, angle reduction constants, CORDIC tables and the payload
// structs passed between the pipeline sections.
// ----------------------------------------------------------------------------
package s2c_pkg;

   // input fields
   localparam int AZ_W    = 16;
   localparam int EL_W    = 15;
   localparam int DIST_W  = 16;
   localparam int REQ_W   = 48;

   // defaults of the top level parameters
   localparam int COORD_WIDTH_DEF = 16;
   localparam int TRIG_STEPS_DEF  = 16;

   // angle reduction: degrees*128 modulo a full turn, then quotient/remainder by 45
   localparam int MOD_TURN  = 46080;
   localparam int DEG_DIV   = 45;
   localparam int RECIP_K   = 93206;   // floor(2^22 / 45)
   localparam int RECIP_SH  = 22;
   localparam int QUOT_W    = 10;
   localparam int REM_W     = 6;
   localparam int BAM_W     = 32;      // binary angle, full circle = 2^32

   // CORDIC datapath
   localparam int ROT_W     = 33;
   localparam int TRIG_W    = 32;
   localparam int TAB_LEN   = 30;
   localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 33'h026DD3B6A;

   typedef logic [BAM_W-1:0] ang_tab_type [TAB_LEN];

   localparam ang_tab_type ANG_TAB = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // low 22 bits of the binary angle for each remainder modulo 45
   typedef logic [RECIP_SH-1:0] frac_tab_type [2**REM_W];

   function automatic frac_tab_type build_frac_tab();
      frac_tab_type tab;
      longint       v;
      for (int i = 0; i < 2**REM_W; i++) begin
         v = (longint'(i) * 4194304 + 22) / DEG_DIV;
         tab[i] = (i < DEG_DIV) ? v[RECIP_SH-1:0] : '0;
      end
      return tab;
   endfunction

   localparam frac_tab_type FRAC_TAB = build_frac_tab();

   // angle section to CORDIC section
   typedef struct packed {
      logic signed [ROT_W-1:0] z_az;
      logic signed [ROT_W-1:0] z_el;
      logic                    flip_az;
      logic                    flip_el;
      logic [DIST_W-1:0]       radius;
   } s2c_rot_type;

   // CORDIC section to scaling section
   typedef struct packed {
      logic signed [ROT_W-1:0] cos_az;
      logic signed [ROT_W-1:0] sin_az;
      logic signed [ROT_W-1:0] cos_el;
      logic signed [ROT_W-1:0] sin_el;
      logic                    flip_az;
      logic                    flip_el;
      logic [DIST_W-1:0]       radius;
   } s2c_trig_type;

endpackage

// ----- rtl/s2c_angle.sv -----
// ----------------------------------------------------------------------------
// s2c_angle: angle reduction
// Wraps azimuth and elevation into one turn, converts degrees*128 to a 32-bit
// binary angle and folds it into +-90 degrees. Five register stages.
// ----------------------------------------------------------------------------
module s2c_angle (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [s2c_pkg::AZ_W-1:0]       azimuth,
   input  logic [s2c_pkg::EL_W-1:0]       elevation,
   input  logic [s2c_pkg::DIST_W-1:0]     distance,
   output logic                           out_valid,
   output s2c_pkg::s2c_rot_type           out_rot
);

   localparam int NSTAGE = 5;
   localparam int M_W    = 16;
   localparam int R0_W   = 7;

   logic [NSTAGE-1:0]               valid_ff;
   logic [s2c_pkg::DIST_W-1:0]      dist_ff [NSTAGE];

   logic signed [M_W:0]             ang_ext [2];

   logic [M_W-1:0]                  m_ff    [2];
   logic [M_W-1:0]                  m2_ff   [2];
   logic [s2c_pkg::BAM_W-1:0]       prod_ff [2];
   logic [s2c_pkg::QUOT_W-1:0]      q0_ff   [2];
   logic [R0_W-1:0]                 r0_ff   [2];
   logic [s2c_pkg::QUOT_W-1:0]      q_ff    [2];
   logic [s2c_pkg::REM_W-1:0]       r_ff    [2];
   logic signed [s2c_pkg::ROT_W-1:0] z_ff   [2];
   logic                            flip_ff [2];

   assign ang_ext[0] = {azimuth[s2c_pkg::AZ_W-1], azimuth};
   assign ang_ext[1] = {{2{elevation[s2c_pkg::EL_W-1]}}, elevation};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NSTAGE-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff[0] <= distance;
         for (int k = 1; k < NSTAGE; k++) begin
            dist_ff[k] <= dist_ff[k-1];
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [M_W-1:0]                  m_in;
      logic [s2c_pkg::BAM_W-1:0]       prod_in;
      logic [M_W-1:0]                  mul45;
      logic [M_W-1:0]                  diff;
      logic                            ge;
      logic [s2c_pkg::QUOT_W-1:0]      q_in;
      logic [s2c_pkg::REM_W-1:0]       r_in;
      logic [s2c_pkg::BAM_W-1:0]       t;
      logic [s2c_pkg::BAM_W-1:0]       tf;
      logic                            flip_in;
      logic signed [s2c_pkg::ROT_W-1:0] z_in;

      always_comb begin
         // stage 1: wrap into [0, 46080)
         m_in = ang_ext[l][M_W] ? M_W'(ang_ext[l] + 17'(s2c_pkg::MOD_TURN))
                                : ang_ext[l][M_W-1:0];
         // stage 2: reciprocal estimate of m / 45
         prod_in = s2c_pkg::BAM_W'(m_ff[l]) * s2c_pkg::BAM_W'(s2c_pkg::RECIP_K);
         // stage 3: estimate is low by at most one, so remainder is below 90
         mul45 = M_W'(prod_ff[l][s2c_pkg::BAM_W-1:s2c_pkg::RECIP_SH]) * M_W'(s2c_pkg::DEG_DIV);
         diff  = m2_ff[l] - mul45;
         // stage 4: one correction step
         ge   = (r0_ff[l] >= R0_W'(s2c_pkg::DEG_DIV));
         q_in = q0_ff[l] + s2c_pkg::QUOT_W'(ge);
         r_in = ge ? s2c_pkg::REM_W'(r0_ff[l] - R0_W'(s2c_pkg::DEG_DIV))
                   : r0_ff[l][s2c_pkg::REM_W-1:0];
         // stage 5: binary angle = q*2^22 + frac(r), fold into +-quarter turn
         t       = {q_ff[l], s2c_pkg::FRAC_TAB[r_ff[l]]};
         flip_in = (!t[31] && t[30] && (|t[29:0])) || (t[31] && !t[30]);
         tf      = flip_in ? {~t[31], t[30:0]} : t;
         z_in    = {tf[31], tf};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[l]    <= m_in;
            m2_ff[l]   <= m_ff[l];
            prod_ff[l] <= prod_in;
            q0_ff[l]   <= prod_ff[l][s2c_pkg::BAM_W-1:s2c_pkg::RECIP_SH];
            r0_ff[l]   <= diff[R0_W-1:0];
            q_ff[l]    <= q_in;
            r_ff[l]    <= r_in;
            z_ff[l]    <= z_in;
            flip_ff[l] <= flip_in;
         end
      end
   end

   assign out_valid       = valid_ff[NSTAGE-1];
   assign out_rot.z_az    = z_ff[0];
   assign out_rot.z_el    = z_ff[1];
   assign out_rot.flip_az = flip_ff[0];
   assign out_rot.flip_el = flip_ff[1];
   assign out_rot.radius  = dist_ff[NSTAGE-1];

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (r0_ff[0] < 7'd90) && (r0_ff[1] < 7'd90))
      else $error("remainder estimate off by more than one divisor");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> (z_ff[0] <= 33'sh040000000) && (z_ff[0] >= -33'sh040000000) &&
                      (z_ff[1] <= 33'sh040000000) && (z_ff[1] >= -33'sh040000000))
      else $error("folded angle outside quarter turn");

endmodule

// ----- rtl/s2c_cordic.sv -----
// ----------------------------------------------------------------------------
// s2c_cordic: pipelined rotation-mode CORDIC
// One register stage per iteration, two lanes (azimuth and elevation) side by
// side. Produces cos and sin in Q30.
// ----------------------------------------------------------------------------
module s2c_cordic #(
   parameter int TRIG_STEPS = s2c_pkg::TRIG_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  s2c_pkg::s2c_rot_type  in_rot,
   output logic                  out_valid,
   output s2c_pkg::s2c_trig_type out_trig
);

   localparam int W = s2c_pkg::ROT_W;

   logic [TRIG_STEPS-1:0]          valid_ff;
   logic signed [W-1:0]            x_ff [TRIG_STEPS][2];
   logic signed [W-1:0]            y_ff [TRIG_STEPS][2];
   logic signed [W-1:0]            z_ff [TRIG_STEPS][2];
   logic [1:0]                     flip_ff [TRIG_STEPS];
   logic [s2c_pkg::DIST_W-1:0]     dist_ff [TRIG_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[TRIG_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flip_ff[0] <= {in_rot.flip_el, in_rot.flip_az};
         dist_ff[0] <= in_rot.radius;
         for (int k = 1; k < TRIG_STEPS; k++) begin
            flip_ff[k] <= flip_ff[k-1];
            dist_ff[k] <= dist_ff[k-1];
         end
      end
   end

   for (genvar k = 0; k < TRIG_STEPS; k++) begin : g_stage
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic signed [W-1:0] x_prev;
         logic signed [W-1:0] y_prev;
         logic signed [W-1:0] z_prev;
         logic signed [W-1:0] x_in;
         logic signed [W-1:0] y_in;
         logic signed [W-1:0] z_in;
         logic signed [W-1:0] atan;

         if (k == 0) begin : g_first
            assign x_prev = s2c_pkg::CORDIC_GAIN;
            assign y_prev = '0;
            assign z_prev = (l == 0) ? in_rot.z_az : in_rot.z_el;
         end else begin : g_next
            assign x_prev = x_ff[k-1][l];
            assign y_prev = y_ff[k-1][l];
            assign z_prev = z_ff[k-1][l];
         end

         assign atan = $signed({1'b0, s2c_pkg::ANG_TAB[k]});

         always_comb begin
            if (!z_prev[W-1]) begin
               x_in = x_prev - (y_prev >>> k);
               y_in = y_prev + (x_prev >>> k);
               z_in = z_prev - atan;
            end else begin
               x_in = x_prev + (y_prev >>> k);
               y_in = y_prev - (x_prev >>> k);
               z_in = z_prev + atan;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[k][l] <= x_in;
               y_ff[k][l] <= y_in;
               z_ff[k][l] <= z_in;
            end
         end
      end
   end

   assign out_valid        = valid_ff[TRIG_STEPS-1];
   assign out_trig.cos_az  = x_ff[TRIG_STEPS-1][0];
   assign out_trig.sin_az  = y_ff[TRIG_STEPS-1][0];
   assign out_trig.cos_el  = x_ff[TRIG_STEPS-1][1];
   assign out_trig.sin_el  = y_ff[TRIG_STEPS-1][1];
   assign out_trig.flip_az = flip_ff[TRIG_STEPS-1][0];
   assign out_trig.flip_el = flip_ff[TRIG_STEPS-1][1];
   assign out_trig.radius  = dist_ff[TRIG_STEPS-1];

endmodule

// ----- rtl/s2c_scale.sv -----
// ----------------------------------------------------------------------------
// s2c_scale: products, rounding, saturation and output buffer
// Undoes the quadrant fold, forms sin(az)cos(el), cos(az)cos(el) and the
// distance products, rounds to the output format and saturates. A two-entry
// output buffer decouples the stream from the stall of the receiver.
// ----------------------------------------------------------------------------
module s2c_scale #(
   parameter int COORD_WIDTH = s2c_pkg::COORD_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     en,
   input  logic                     in_valid,
   input  s2c_pkg::s2c_trig_type    in_trig,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [3*COORD_WIDTH-1:0] out_data
);

   localparam int NSTAGE = 5;
   localparam int TW     = s2c_pkg::TRIG_W;
   localparam int PW     = 2 * TW;
   localparam int DW     = s2c_pkg::DIST_W + 1;
   localparam int ZW     = DW + TW;
   localparam int HW     = 34;
   localparam int QW     = DW + HW;
   localparam int SH     = 46 - COORD_WIDTH;
   localparam int OW     = 3 * COORD_WIDTH;
   localparam logic signed [PW-1:0] HALF30 = PW'(64'sd1 <<< 29);
   localparam logic signed [QW-1:0] HALF_O = QW'(64'sd1 <<< (SH - 1));
   localparam logic signed [QW-1:0] LIM    = QW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);

   function automatic logic [COORD_WIDTH-1:0] round_sat(input logic signed [QW-1:0] q);
      logic signed [QW-1:0] v;
      v = (q + HALF_O) >>> SH;
      if (v > LIM) begin
         v = LIM;
      end else if (v < -LIM) begin
         v = -LIM;
      end
      return v[COORD_WIDTH-1:0];
   endfunction

   logic [NSTAGE-1:0]           valid_ff;
   logic [s2c_pkg::DIST_W-1:0]  dist_ff [3];

   // stage 1: unfolded trig values
   logic signed [TW-1:0] caz_ff, saz_ff, cel_ff, sel_ff;
   // stage 2: raw products
   logic signed [PW-1:0] pxp_ff, pyp_ff;
   logic signed [ZW-1:0] pzp_ff;
   // stage 3: horizontal factors back in Q30
   logic signed [HW-1:0] hx_ff, hy_ff;
   logic signed [ZW-1:0] pz3_ff;
   // stage 4: distance products, Q45
   logic signed [QW-1:0] qx_ff, qy_ff, qz_ff;
   // stage 5: rounded and saturated
   logic [OW-1:0]        res_ff;

   logic signed [s2c_pkg::ROT_W-1:0] caz_in, saz_in, cel_in, sel_in;
   logic signed [DW-1:0]             dist3_s;

   logic          leave_valid;
   logic          out_valid_ff, out_valid_in;
   logic          skid_valid_ff, skid_valid_in;
   logic [OW-1:0] out_data_ff, out_data_in;
   logic [OW-1:0] skid_data_ff, skid_data_in;

   // whole pipeline halts only while the spare output entry is occupied
   assign en = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NSTAGE-2:0], in_valid};
      end
   end

   always_comb begin
      caz_in  = in_trig.flip_az ? -in_trig.cos_az : in_trig.cos_az;
      saz_in  = in_trig.flip_az ? -in_trig.sin_az : in_trig.sin_az;
      cel_in  = in_trig.flip_el ? -in_trig.cos_el : in_trig.cos_el;
      sel_in  = in_trig.flip_el ? -in_trig.sin_el : in_trig.sin_el;
      dist3_s = $signed({1'b0, dist_ff[2]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff[0] <= in_trig.radius;
         for (int k = 1; k < 3; k++) begin
            dist_ff[k] <= dist_ff[k-1];
         end
         caz_ff <= caz_in[TW-1:0];
         saz_ff <= saz_in[TW-1:0];
         cel_ff <= cel_in[TW-1:0];
         sel_ff <= sel_in[TW-1:0];

         pxp_ff <= PW'(saz_ff) * PW'(cel_ff);
         pyp_ff <= PW'(caz_ff) * PW'(cel_ff);
         pzp_ff <= ZW'($signed({1'b0, dist_ff[0]})) * ZW'(sel_ff);

         hx_ff  <= HW'((pxp_ff + HALF30) >>> 30);
         hy_ff  <= HW'((pyp_ff + HALF30) >>> 30);
         pz3_ff <= pzp_ff;

         qx_ff  <= QW'(dist3_s) * QW'(hx_ff);
         qy_ff  <= QW'(dist3_s) * QW'(hy_ff);
         qz_ff  <= QW'(pz3_ff);

         res_ff <= {round_sat(qz_ff), round_sat(qy_ff), round_sat(qx_ff)};
      end
   end

   assign leave_valid = valid_ff[NSTAGE-1] && en;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_ready) begin
         out_valid_in = leave_valid;
         out_data_in  = res_ff;
      end else if (leave_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("spare entry filled while output register empty");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && !skid_valid_ff)
      else $error("spare entry not moved to output");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |->
         (out_data_ff[COORD_WIDTH-1:0] != {1'b1, {(COORD_WIDTH-1){1'b0}}}) &&
         (out_data_ff[2*COORD_WIDTH-1:COORD_WIDTH] != {1'b1, {(COORD_WIDTH-1){1'b0}}}) &&
         (out_data_ff[OW-1:2*COORD_WIDTH] != {1'b1, {(COORD_WIDTH-1){1'b0}}}))
      else $error("coordinate escaped symmetric saturation");

endmodule

// ----- rtl/spherical_to_cartesian.sv -----
// ----------------------------------------------------------------------------
// spherical_to_cartesian: polar to Cartesian object position converter
//
// req_ channel: one beat carries azimuth and elevation (degrees*128, two's
// complement) and a distance in unsigned Q1.15. rsp_ channel: one beat per
// request with x (right), y (front) and z (up) in signed Q1.(COORD_WIDTH-1),
// saturated to +-(2^(COORD_WIDTH-1)-1). Angles wrap modulo 360 degrees.
//
// Throughput: one beat per cycle while rsp_tready stays high. Depth:
// TRIG_STEPS + 11 register stages: five stages of angle reduction, one
// stage per CORDIC iteration, five stages of multiply, round and saturate,
// then the output register.
//
// Reset clears all valid bits; nothing else is held between beats.
// When rsp_tready is low a finished beat waits in the output register and
// one more is parked in a spare entry; only then does the pipeline halt and
// req_tready go low. req_tready comes straight from a flop.
// ----------------------------------------------------------------------------
module spherical_to_cartesian #(
   parameter int COORD_WIDTH = s2c_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_STEPS  = s2c_pkg::TRIG_STEPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // azimuth [15:0], elevation [30:16], distance [46:31], zero [47]
   input  logic [s2c_pkg::REQ_W-1:0]              req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // pos_x, pos_y, pos_z, COORD_WIDTH bits each from bit 0 up, zero fill
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     rsp_tdata
);

   localparam int RSP_W = ((3 * COORD_WIDTH + 7) / 8) * 8;
   localparam int EL_LO = s2c_pkg::AZ_W;
   localparam int D_LO  = s2c_pkg::AZ_W + s2c_pkg::EL_W;

   logic                      en;
   logic                      rot_valid;
   logic                      trig_valid;
   s2c_pkg::s2c_rot_type      rot;
   s2c_pkg::s2c_trig_type     trig;
   logic [3*COORD_WIDTH-1:0]  res_data;

   assign req_tready = en;

   s2c_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid && en),
      .azimuth   (req_tdata[s2c_pkg::AZ_W-1:0]),
      .elevation (req_tdata[D_LO-1:EL_LO]),
      .distance  (req_tdata[D_LO+s2c_pkg::DIST_W-1:D_LO]),
      .out_valid (rot_valid),
      .out_rot   (rot)
   );

   s2c_cordic #(
      .TRIG_STEPS (TRIG_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rot_valid),
      .in_rot    (rot),
      .out_valid (trig_valid),
      .out_trig  (trig)
   );

   s2c_scale #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (trig_valid),
      .in_trig   (trig),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res_data)
   );

   assign rsp_tdata = RSP_W'(res_data);

endmodule

// ----- tb/spherical_to_cartesian_test.sv -----
// ----------------------------------------------------------------------------
// spherical_to_cartesian_test: self-checking bench for the polar to Cartesian
// converter
// Drives positions on the req_ stream and checks each rsp_ beat against a
// bit-exact CORDIC predictor held in a scoreboard. A short directed set of
// corners is followed by random positions under three idling mixes.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_test;

   timeunit 1ns;
   timeprecision 1ps;

   class position_scoreboard;

      localparam int COORD_W = 16;
      localparam int STEPS   = 16;
      localparam int RSP_W   = ((3*COORD_W+7)/8)*8;

      typedef struct {
         logic signed [COORD_W-1:0] x;
         logic signed [COORD_W-1:0] y;
         logic signed [COORD_W-1:0] z;
      } cart_pos_type;

      cart_pos_type expected_positions[$];
      int           error_count = 0;

      // arctangent of 2^-i as a binary angle, full circle = 2^32
      static function longint atan_bam(int i);
         case (i)
            0:  return 64'h20000000;  1: return 64'h12E4051E;  2: return 64'h09FB385B;
            3:  return 64'h051111D4;  4: return 64'h028B0D43;  5: return 64'h0145D7E1;
            6:  return 64'h00A2F61E;  7: return 64'h00517C55;  8: return 64'h0028BE53;
            9:  return 64'h00145F2F; 10: return 64'h000A2F98; 11: return 64'h000517CC;
            12: return 64'h00028BE6; 13: return 64'h000145F3; 14: return 64'h0000A2FA;
            15: return 64'h0000517D; 16: return 64'h000028BE; 17: return 64'h0000145F;
            18: return 64'h00000A30; 19: return 64'h00000518; 20: return 64'h0000028C;
            21: return 64'h00000146; 22: return 64'h000000A3; 23: return 64'h00000051;
            24: return 64'h00000029; 25: return 64'h00000014; 26: return 64'h0000000A;
            27: return 64'h00000005; 28: return 64'h00000003; default: return 64'h1;
         endcase
      endfunction

      // cos and sin in Q30 of an angle given in degrees*128
      static function void cordic_sin_cos(input longint deg128,
                                          output longint cos_q30,
                                          output longint sin_q30);
         longint m, t, x, y, z, dx, dy;
         bit     flip;
         m = deg128 % 46080;
         if (m < 0)
            m += 46080;
         t = ((m <<< 22) + 22) / 45;
         if (t >= 64'sd2147483648)
            t -= 64'sd4294967296;
         flip = 1'b0;
         // fold into +-90 degrees, negate results afterwards
         if (t > 64'sd1073741824) begin
            t -= 64'sd2147483648;
            flip = 1'b1;
         end else if (t < -64'sd1073741824) begin
            t += 64'sd2147483648;
            flip = 1'b1;
         end
         x = 64'sh26DD3B6A;
         y = 0;
         z = t;
         for (int i = 0; i < STEPS && i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= atan_bam(i);
            end else begin
               x += dx;
               y -= dy;
               z += atan_bam(i);
            end
         end
         cos_q30 = flip ? -x : x;
         sin_q30 = flip ? -y : y;
      endfunction

      static function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s-1))) >>> s;
      endfunction

      // Q45 to Q1.(COORD_W-1), rounded half up, saturated symmetric
      static function logic signed [COORD_W-1:0] scale_round_sat(longint q45);
         longint v, lim;
         lim = (longint'(1) <<< (COORD_W-1)) - 1;
         v = round_shift(q45, 46 - COORD_W);
         if (v > lim)
            v = lim;
         if (v < -lim)
            v = -lim;
         return v[COORD_W-1:0];
      endfunction

      function void note_request(logic [47:0] data);
         longint       az, el, radius, caz, saz, cel, sel;
         cart_pos_type p;
         az     = longint'($signed(data[15:0]));
         el     = longint'($signed(data[30:16]));
         radius = longint'(data[46:31]);
         cordic_sin_cos(az, caz, saz);
         cordic_sin_cos(el, cel, sel);
         p.x = scale_round_sat(radius * round_shift(saz * cel, 30));
         p.y = scale_round_sat(radius * round_shift(caz * cel, 30));
         p.z = scale_round_sat(radius * sel);
         expected_positions.insert(expected_positions.size(), p);
      endfunction

      function void check_response(logic [RSP_W-1:0] data);
         cart_pos_type              p;
         logic signed [COORD_W-1:0] ax, ay, az;
         ax = data[COORD_W-1:0];
         ay = data[2*COORD_W-1:COORD_W];
         az = data[3*COORD_W-1:2*COORD_W];
         if (expected_positions.size() == 0) begin
            $error("unexpected rsp beat: x %0d y %0d z %0d", ax, ay, az);
            error_count++;
            return;
         end
         p = expected_positions.pop_front();
         if (ax !== p.x) begin
            $error("pos_x mismatch: expected %0d, actual %0d", p.x, ax);
            error_count++;
         end
         if (ay !== p.y) begin
            $error("pos_y mismatch: expected %0d, actual %0d", p.y, ay);
            error_count++;
         end
         if (az !== p.z) begin
            $error("pos_z mismatch: expected %0d, actual %0d", p.z, az);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_positions.size();
      endfunction

   endclass

   localparam int COORD_W = position_scoreboard::COORD_W;
   localparam int STEPS   = position_scoreboard::STEPS;
   localparam int RSP_W   = position_scoreboard::RSP_W;
   localparam int LATENCY = STEPS + 11;
   localparam int RANDOM_PER_PHASE = 535;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   // azimuth [15:0], elevation [30:16], distance [46:31], zero [47]
   logic [47:0]        req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   // pos_x [15:0], pos_y [31:16], pos_z [47:32]
   logic [RSP_W-1:0]   rsp_tdata;

   position_scoreboard sb = new();
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;

   spherical_to_cartesian #(
      .COORD_WIDTH (COORD_W),
      .TRIG_STEPS  (STEPS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // beat monitors, sampling pre-edge values
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_position(logic signed [15:0] az, logic signed [14:0] el,
                                logic [15:0] radius);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, radius, el, az};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic send_random_position();
      logic signed [15:0] az;
      logic signed [14:0] el;
      logic [15:0]        radius;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
         az = 16'(int'($urandom_range(46080)) - 23040);
         el = 15'(int'($urandom_range(23040)) - 11520);
      end else if (pick < 85) begin
         // exact multiples of 90 degrees
         az = 16'(int'($urandom_range(4)) * 11520 - 23040);
         el = 15'(int'($urandom_range(2)) * 11520 - 11520);
      end else begin
         // any bit pattern, angles wrap
         az = 16'($urandom);
         el = 15'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 80)
         radius = 16'($urandom_range(32768));
      else if (pick < 92)
         radius = 16'($urandom);
      else
         radius = ($urandom_range(1) == 1) ? 16'd32768 : 16'd0;
      send_position(az, el, radius);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      // let the monitor note the last accepted beat first
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_position(16'sd0, 15'sd0, 16'd32768);
      send_position(16'sd23040, 15'sd0, 16'd32768);
      send_position(-16'sd23040, 15'sd0, 16'd32768);
      send_position(16'sd11520, 15'sd0, 16'd32768);
      send_position(-16'sd11520, 15'sd0, 16'd32768);
      send_position(16'sd0, 15'sd11520, 16'd32768);
      send_position(16'sd0, -15'sd11520, 16'd32768);
      send_position(16'sd5760, 15'sd5760, 16'd32768);
      send_position(-16'sd17280, -15'sd5760, 16'd32768);
      // zero distance
      send_position(16'sd1234, 15'sd4321, 16'd0);
      // distance above 1.0 saturates
      send_position(16'sd0, 15'sd0, 16'hFFFF);
      send_position(16'sd5760, 15'sd0, 16'hFFFF);
      send_position(-16'sd23040, -15'sd11520, 16'hFFFF);
      // out-of-range angles wrap
      send_position(16'sh7FFF, 15'sh3FFF, 16'd20000);
      send_position(-16'sh8000, -15'sh4000, 16'd20000);
      send_position(16'sd30000, 15'sd16000, 16'd32768);
      send_position(-16'sd30000, -15'sd16000, 16'd32768);
      send_position(16'sd23041, 15'sd11521, 16'd32767);
      send_position(-16'sd1, -15'sd1, 16'd1);
      send_position(16'sd1, 15'sd1, 16'd32768);
      send_position(16'sd11519, 15'sd11519, 16'd32768);
      send_position(16'sd11521, 15'sd11521, 16'hFFFF);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 55 : 0;
         recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 10 : 0;
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_random_position();
         wait_drained();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

endmodule
